// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the formatter project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FWDF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FWDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fwdf_pkg.sv
// ----------------------------------------------------------------------------
// Formatter package
// Types and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package fwdf_pkg;

    localparam logic [5:0]  CHAR_SPACE  = 6'h20;
    localparam logic [5:0]  CHAR_ZERO   = 6'h30;
    // x / 10 == (x * 52429) >> 19 for every 16-bit x.
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_count_zero;
        logic conv_done;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

// File: rtl/fwdf_datapath.sv
// ----------------------------------------------------------------------------
// Formatter datapath
// Divide-by-ten unit, character slot file and output register.
// ----------------------------------------------------------------------------
module fwdf_datapath #(
    parameter int MAX_DIGITS = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_value,
    input  logic [2:0]       i_digit_count,
    input  logic             i_fill_zero,
    input  fwdf_pkg::t_cmd   i_cmd,
    output fwdf_pkg::t_status o_status,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [5:0]       o_char_code,
    output logic             o_out_last
);
    import fwdf_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [15:0]      r_value;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_emit;
    logic [5:0]       r_slots [MAX_DIGITS];
    logic             r_out_valid;
    logic [5:0]       r_out_char;
    logic             r_out_last;

    logic [31:0]      w_prod;
    logic [12:0]      w_quot;
    logic [15:0]      w_quot10;
    logic [3:0]       w_rem;
    logic [CNT_W-1:0] w_count_in;
    logic [5:0]       w_pad;

    always_comb begin
        if (32'(i_digit_count) > MAX_DIGITS) begin
            w_count_in = CNT_W'(MAX_DIGITS);
        end else begin
            w_count_in = CNT_W'(i_digit_count);
        end
    end

    assign w_pad    = i_fill_zero ? CHAR_ZERO : CHAR_SPACE;
    assign w_prod   = 32'(r_value) * 32'(DIV10_MUL);
    assign w_quot   = 13'(w_prod >> DIV10_SHIFT);
    assign w_quot10 = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
    assign w_rem    = 4'(r_value - w_quot10);

    // Conversion stops at the first zero quotient or when the field is full.
    assign o_status.in_count_zero = (i_digit_count == 3'd0);
    assign o_status.conv_done     = (w_quot == 13'd0) ||
                                    ((CNT_W'(r_pos) + CNT_W'(1)) == r_count);
    assign o_status.emit_last     = (r_emit == '0);
    assign o_status.out_free      = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_count <= w_count_in;
            r_pos   <= '0;
            r_emit  <= IDX_W'(w_count_in - CNT_W'(1));
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_slots[i] <= w_pad;
            end
        end else if (i_cmd.step) begin
            r_slots[r_pos] <= CHAR_ZERO + {2'b00, w_rem};
            r_value        <= {3'b000, w_quot};
            r_pos          <= r_pos + IDX_W'(1);
        end else if (i_cmd.emit) begin
            r_emit <= r_emit - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= r_slots[r_emit];
            r_out_last <= (r_emit == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// File: rtl/fwdf_controller.sv
// ----------------------------------------------------------------------------
// Formatter controller
// Sequences load, digit conversion and character emission.
// ----------------------------------------------------------------------------
module fwdf_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  fwdf_pkg::t_status i_status,
    output logic              o_in_ready,
    output fwdf_pkg::t_cmd    o_cmd
);
    import fwdf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                // A request with a zero count is taken and produces nothing.
                if (i_in_valid && !i_status.in_count_zero) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (i_status.conv_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && !i_status.in_count_zero;
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/fixed_width_decimal_formatter_unit.sv
// ----------------------------------------------------------------------------
// Fixed-width decimal formatter
// Turns a 16-bit unsigned value into a right-aligned field of ASCII digits.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one request carries value, digit count and fill
// choice. The count is saturated to MAX_DIGITS; a zero count is accepted
// and produces no characters.
// Output stream (m_axis): one ASCII character per transfer, most significant
// position first, with tlast on the final character of the field. Unused
// upper positions carry a space or '0'; digits beyond the field are dropped.
// Timing: the request is loaded, then the single divide-by-ten unit
// produces one digit per cycle until the quotient is zero or the field
// is full (1 to count digits), then one character leaves per cycle while
// the receiver takes them. The block takes no new request until the last
// character of the previous field has been moved to the output register.
// A receiver stall holds the output register and pauses emission; the next
// request may be accepted while the last character still waits.
// Reset (synchronous, active low) returns the controller to idle and empties
// the output register.
// ----------------------------------------------------------------------------
module fixed_width_decimal_formatter_unit #(
    parameter int MAX_DIGITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] value, [18:16] digit_count, [19] fill_zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] char_code
    output logic        m_axis_tlast
);
    import fwdf_pkg::*;

    t_cmd       w_cmd;
    t_status    w_status;
    logic [5:0] w_char_code;

    fwdf_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    fwdf_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (s_axis_tdata[15:0]),
        .i_digit_count (s_axis_tdata[18:16]),
        .i_fill_zero   (s_axis_tdata[19]),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_char_code   (w_char_code),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_char_code};

endmodule

// File: rtl/fwdf_checker.sv
// ----------------------------------------------------------------------------
// Formatter port checker
// Observes the top-level ports and checks stream behavior over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fwdf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled character must hold until it is taken.
    `FWDF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled character changed")

    // Every character is a space or a decimal digit.
    `FWDF_ASSERT_IMPL(a_char_legal, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata == 8'h20) || ((m_axis_tdata[7:4] == 4'h3) && (m_axis_tdata[3:0] <= 4'd9)), "illegal character code")

    // A request that produces characters blocks the next one while it converts.
    `FWDF_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tdata[18:16] != 3'd0), !s_axis_tready, "request taken during conversion")

    // The output cannot become valid in the cycle right after a request.
    `FWDF_ASSERT_NEXT(a_no_early_out, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "character before conversion")

endmodule

bind fixed_width_decimal_formatter_unit fwdf_checker u_fwdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Formatter testbench
// Drives value, digit count and fill requests into the fixed-width decimal
// formatter and checks every ASCII character and its tlast against a
// predicted field. The stimulus covers directed edge values, random values,
// a long receiver hold-off and pauses until all characters have arrived.
// ----------------------------------------------------------------------------
module tb_top;

    import fwdf_pkg::*;

    localparam int FIELD_MAX    = 5;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct {
        logic [5:0] code;
        logic       last;
    } t_char_exp;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    t_char_exp   expected_chars[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          gaps_off = 1'b0;
    int          hold_request = 0;
    int          hold_left = 0;
    t_rx_mode    rx_mode = RX_ALWAYS;
    int          rx_mode_left = 0;
    int unsigned rx_cycle = 0;

    fixed_width_decimal_formatter_unit #(
        .MAX_DIGITS(FIELD_MAX)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // [15:0] value, [18:16] digit_count, [19] fill_zero
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // [5:0] char_code
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Builds the characters of one field, most significant position first.
    function automatic void format_field(input logic [15:0] value,
                                         input logic [2:0] digit_count,
                                         input logic fill_zero);
        logic [5:0]  slot[FIELD_MAX];
        logic [5:0]  pad;
        int unsigned width;
        int unsigned remain;
        t_char_exp   ch;
        width  = (digit_count > FIELD_MAX) ? FIELD_MAX : digit_count;
        pad    = fill_zero ? CHAR_ZERO : CHAR_SPACE;
        remain = value;
        for (int p = 0; p < FIELD_MAX; p++)
            slot[p] = pad;
        for (int p = 0; p < width; p++) begin
            slot[p] = CHAR_ZERO + 6'(remain % 10);
            remain  = remain / 10;
            if (remain == 0)
                break;
        end
        for (int k = 0; k < width; k++) begin
            ch.code = slot[width - 1 - k];
            ch.last = (k == width - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    // Offers one request and returns once it is taken and any gap after it has
    // passed. The valid stays high unless a gap follows, so back-to-back calls stream.
    task automatic send_request(input logic [15:0] value, input logic [2:0] digit_count,
                                input logic fill_zero);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, fill_zero, digit_count, value};
        @(negedge i_clk);
        while (!s_axis_tready)
            @(negedge i_clk);
        @(posedge i_clk);
        format_field(value, digit_count, fill_zero);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0 || gaps_off) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 9));
            1: return 16'($urandom_range(10, 999));
            2: return 16'($urandom_range(1000, 65535));
            3: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [2:0] pick_count();
        if ($urandom_range(0, 3) == 0)
            return 3'($urandom_range(0, 7));
        return 3'($urandom_range(1, FIELD_MAX));
    endfunction

    task automatic test_directed();
        send_request(16'd0, 3'd1, 1'b0);
        send_request(16'd0, 3'd5, 1'b0);
        send_request(16'd0, 3'd5, 1'b1);
        send_request(16'd0, 3'd0, 1'b1);
        send_request(16'd65535, 3'd5, 1'b0);
        send_request(16'd65535, 3'd7, 1'b1);
        send_request(16'd65535, 3'd3, 1'b0);
        send_request(16'd65535, 3'd0, 1'b0);
        send_request(16'd12345, 3'd5, 1'b1);
        send_request(16'd12345, 3'd6, 1'b0);
        send_request(16'd100, 3'd2, 1'b0);
        send_request(16'd100, 3'd2, 1'b1);
        send_request(16'd7, 3'd1, 1'b0);
        send_request(16'd9, 3'd4, 1'b0);
        send_request(16'd10, 3'd4, 1'b1);
        send_request(16'd42, 3'd4, 1'b0);
        send_request(16'd42, 3'd4, 1'b1);
        send_request(16'd99, 3'd2, 1'b0);
        send_request(16'd10000, 3'd7, 1'b0);
        send_request(16'd9999, 3'd5, 1'b1);
        send_request(16'd43690, 3'd6, 1'b1);
        send_request(16'd21845, 3'd5, 1'b0);
        wait_for_drain();
    endtask

    task automatic test_random(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 40) == 0)
                gaps_off = ~gaps_off;
            send_request(pick_value(), pick_count(), 1'($urandom_range(0, 1)));
        end
        gaps_off = 1'b0;
        wait_for_drain();
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the
    // block has to push back on its input.
    task automatic test_backpressure();
        gaps_off     = 1'b1;
        hold_request = HOLD_OFF_CYCLES;
        for (int i = 0; i < 25; i++)
            send_request(pick_value(), 3'($urandom_range(1, FIELD_MAX)),
                         1'($urandom_range(0, 1)));
        gaps_off = 1'b0;
        wait_for_drain();
    endtask

    task automatic test_drain_pauses();
        for (int g = 0; g < 4; g++) begin
            for (int i = 0; i < 3; i++)
                send_request(pick_value(), pick_count(), 1'($urandom_range(0, 1)));
            wait_for_drain();
        end
    endtask

    // Receiver: the stall pattern is redrawn at random when its span runs out;
    // a hold-off request from a test overrides it and holds tready low.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 120);
        end else begin
            rx_mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:   m_axis_tready <= 1'b1;
                RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 2) != 0);
                RX_PERIODIC: m_axis_tready <= (rx_cycle % 4 != 3);
                default:     m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Inputs only change at the rising edge, so the falling edge sees exactly
    // what the next rising edge will transfer.
    always @(negedge i_clk) begin
        t_char_exp exp_ch;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected character: got %h last %b",
                                 m_axis_tdata[5:0], m_axis_tlast);
                end else begin
                    exp_ch = expected_chars.pop_front();
                    if (m_axis_tdata[5:0] !== exp_ch.code || m_axis_tlast !== exp_ch.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("character error: expected %h last %b, got %h last %b",
                                     exp_ch.code, exp_ch.last, m_axis_tdata[5:0],
                                     m_axis_tlast);
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("fixed_width_decimal_formatter_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(170);
        test_backpressure();
        test_drain_pauses();
        if (error_count == 0)
            $display("fixed_width_decimal_formatter_unit: match");
        else
            $display("fixed_width_decimal_formatter_unit: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/fwdf_pkg.sv
rtl/fwdf_datapath.sv
rtl/fwdf_controller.sv
rtl/fixed_width_decimal_formatter_unit.sv
rtl/fwdf_checker.sv
bench/tb_top.sv
